>>> design/fmm_pkg.sv
// Shared constants, configuration port type and size clamp for the frame
// min/max/mean statistics block. No dependencies.
package fmm_pkg;

    localparam int unsigned FMM_MAX_WIDTH  = 4096;
    localparam int unsigned FMM_MAX_HEIGHT = 4096;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam int unsigned PIXEL_W    = 8;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned QUOT_W     = 8;

    localparam logic [PIXEL_W-1:0]    PIXEL_MAX     = 8'hFF;
    localparam logic [CFG_DATA_W-1:0] RESET_WIDTH   = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT  = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // zero reads as one, anything above the limit reads as the limit
    function automatic logic [31:0] clamp_size(input logic [CFG_DATA_W-1:0] v,
                                               input logic [31:0] limit);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0) begin
            x = 32'd1;
        end
        if (x > limit) begin
            x = limit;
        end
        return x;
    endfunction

endpackage

>>> design/frame_min_max_mean.sv
// Minimum, maximum and rounded mean of one grey frame: takes one 8-bit pixel
// per cycle in raster order unless the frame queue is full, and gives one
// result per frame of width x height pixels. After its last pixel, a frame's
// record passes the queue handoff, a load step, eight steps of the shared
// restoring divider and the output register. A two-entry frame queue sits
// between the pixel front end and the divider, so pixels flow at one per
// cycle while the divider works until the queue is full; short frames are
// paced by the divider. Size writes take effect on the next pixel.
module frame_min_max_mean import fmm_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = FMM_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = FMM_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIXEL_W-1:0]    s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIXEL_W-1:0]    m_min_value,
    output logic [PIXEL_W-1:0]    m_max_value,
    output logic [PIXEL_W-1:0]    m_mean_value
);

    localparam longint unsigned MAX_PIX =
        longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
    localparam int unsigned CNT_W = $clog2(MAX_PIX + 1);
    localparam int unsigned SUM_W = CNT_W + PIXEL_W;
    localparam int unsigned REC_W = 2 * PIXEL_W + SUM_W + CNT_W;

    cfg_write_t       cfg;
    logic             push;
    logic [REC_W-1:0] push_data;
    logic             q_full;
    logic             pop;
    logic             pop_valid;
    logic [REC_W-1:0] pop_data;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_wdata;

    fmm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CNT_W      (CNT_W),
        .SUM_W      (SUM_W),
        .REC_W      (REC_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .push_full (q_full),
        .push      (push),
        .push_data (push_data)
    );

    fmm_queue #(
        .DATA_W (REC_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    fmm_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W),
        .REC_W (REC_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_data     (pop_data),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_min_value  (m_min_value),
        .m_max_value  (m_max_value),
        .m_mean_value (m_mean_value)
    );

endmodule

>>> design/fmm_front.sv
// Front end: size registers, pixel accept and running min/max/sum/count.
// Pushes one finished frame record into the queue. Depends on fmm_pkg.
module fmm_front import fmm_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = FMM_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = FMM_MAX_HEIGHT,
    parameter int unsigned CNT_W      = 25,
    parameter int unsigned SUM_W      = 33,
    parameter int unsigned REC_W      = 2 * PIXEL_W + SUM_W + CNT_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_write_t         cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIXEL_W-1:0] s_pixel,
    input  logic               push_full,
    output logic               push,
    output logic [REC_W-1:0]   push_data
);

    localparam int unsigned W_W    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned PROD_W = W_W + H_W;
    localparam logic [W_W-1:0] RST_W = W_W'(clamp_size(RESET_WIDTH, 32'(MAX_WIDTH)));
    localparam logic [H_W-1:0] RST_H = H_W'(clamp_size(RESET_HEIGHT, 32'(MAX_HEIGHT)));
    localparam logic [CNT_W-1:0] RST_TOTAL = CNT_W'(PROD_W'(RST_W) * PROD_W'(RST_H));

    logic [W_W-1:0]     width_reg,  width_next;
    logic [H_W-1:0]     height_reg, height_next;
    logic [CNT_W-1:0]   total_reg,  total_next;
    logic [PIXEL_W-1:0] min_reg,    min_next;
    logic [PIXEL_W-1:0] max_reg,    max_next;
    logic [SUM_W-1:0]   sum_reg,    sum_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [PROD_W-1:0]  prod;
    logic               accept;
    logic               last;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        unique case (cfg.index)
            REG_FRAME_WIDTH: begin
                width_next = W_W'(clamp_size(cfg.data, 32'(MAX_WIDTH)));
            end
            REG_FRAME_HEIGHT: begin
                height_next = H_W'(clamp_size(cfg.data, 32'(MAX_HEIGHT)));
            end
            default: ;
        endcase
        prod       = PROD_W'(width_next) * PROD_W'(height_next);
        total_next = CNT_W'(prod);
    end

    assign s_ready = !push_full;
    assign accept  = s_valid && s_ready;

    assign min_next   = (s_pixel < min_reg) ? s_pixel : min_reg;
    assign max_next   = (s_pixel > max_reg) ? s_pixel : max_reg;
    assign sum_next   = sum_reg + SUM_W'(s_pixel);
    assign count_next = count_reg + CNT_W'(1);
    assign last       = count_next >= total_reg;

    assign push      = accept && last;
    assign push_data = {min_next, max_next, sum_next, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_W;
            height_reg <= RST_H;
            total_reg  <= RST_TOTAL;
            min_reg    <= PIXEL_MAX;
            max_reg    <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg.we) begin
                width_reg  <= width_next;
                height_reg <= height_next;
                total_reg  <= total_next;
            end
            if (accept) begin
                if (last) begin
                    min_reg   <= PIXEL_MAX;
                    max_reg   <= '0;
                    sum_reg   <= '0;
                    count_reg <= '0;
                end else begin
                    min_reg   <= min_next;
                    max_reg   <= max_next;
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                end
            end
        end
    end

endmodule

>>> design/fmm_queue.sv
// Short FIFO of finished frame records between front and back end.
// Depends on fmm_pkg for the default depth.
module fmm_queue import fmm_pkg::*; #(
    parameter int unsigned DATA_W = 82,
    parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg,   fill_next;
    logic              do_push;
    logic              do_pop;

    assign full      = fill_reg == FILL_W'(DEPTH);
    assign pop_valid = fill_reg != '0;
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> design/fmm_back.sv
// Back end: rounded mean by an 8-step restoring divider, result register
// on the output channel. Depends on fmm_pkg.
module fmm_back import fmm_pkg::*; #(
    parameter int unsigned CNT_W = 25,
    parameter int unsigned SUM_W = 33,
    parameter int unsigned REC_W = 2 * PIXEL_W + SUM_W + CNT_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    input  logic [REC_W-1:0]   pop_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIXEL_W-1:0] m_min_value,
    output logic [PIXEL_W-1:0] m_max_value,
    output logic [PIXEL_W-1:0] m_mean_value
);

    localparam int unsigned STEP_W = $clog2(QUOT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } back_state_t;

    back_state_t        state_reg,   state_next;
    logic [SUM_W-1:0]   rem_reg,     rem_next;
    logic [SUM_W-1:0]   dsh_reg,     dsh_next;
    logic [QUOT_W-1:0]  quot_reg,    quot_next;
    logic [STEP_W-1:0]  step_reg,    step_next;
    logic [PIXEL_W-1:0] fmin_reg,    fmin_next;
    logic [PIXEL_W-1:0] fmax_reg,    fmax_next;
    logic               m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0] m_min_reg,   m_min_next;
    logic [PIXEL_W-1:0] m_max_reg,   m_max_next;
    logic [PIXEL_W-1:0] m_mean_reg,  m_mean_next;

    logic [PIXEL_W-1:0] rec_min;
    logic [PIXEL_W-1:0] rec_max;
    logic [SUM_W-1:0]   rec_sum;
    logic [CNT_W-1:0]   rec_cnt;
    logic               fits;

    assign rec_min = pop_data[REC_W-1 -: PIXEL_W];
    assign rec_max = pop_data[REC_W-PIXEL_W-1 -: PIXEL_W];
    assign rec_sum = pop_data[CNT_W +: SUM_W];
    assign rec_cnt = pop_data[0 +: CNT_W];

    assign pop  = pop_valid && (state_reg == ST_IDLE);
    assign fits = rem_reg >= dsh_reg;

    always_comb begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quot_next    = quot_reg;
        step_next    = step_reg;
        fmin_next    = fmin_reg;
        fmax_next    = fmax_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_min_next   = m_min_reg;
        m_max_next   = m_max_reg;
        m_mean_next  = m_mean_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    rem_next   = rec_sum + SUM_W'(rec_cnt >> 1);
                    dsh_next   = SUM_W'({rec_cnt, {(QUOT_W-1){1'b0}}});
                    quot_next  = '0;
                    step_next  = STEP_W'(QUOT_W - 1);
                    fmin_next  = rec_min;
                    fmax_next  = rec_max;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (fits) begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next  = dsh_reg >> 1;
                quot_next = {quot_reg[QUOT_W-2:0], fits};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_min_next   = fmin_reg;
                    m_max_next   = fmax_reg;
                    m_mean_next  = quot_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        fmin_reg   <= fmin_next;
        fmax_reg   <= fmax_next;
        m_min_reg  <= m_min_next;
        m_max_reg  <= m_max_next;
        m_mean_reg <= m_mean_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_min_value  = m_min_reg;
    assign m_max_value  = m_max_reg;
    assign m_mean_value = m_mean_reg;

endmodule

>>> design/fmm_checker.sv
// Port-level checks for frame_min_max_mean, attached by bind.
// Depends on fmm_pkg.
module fmm_checker import fmm_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [PIXEL_W-1:0] m_min_value,
    input logic [PIXEL_W-1:0] m_max_value,
    input logic [PIXEL_W-1:0] m_mean_value
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_value)
            && $stable(m_max_value) && $stable(m_mean_value))
        else $error("result beat changed while stalled");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_min_value <= m_max_value)
        else $error("minimum above maximum");

    a_mean_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_mean_value >= m_min_value && m_mean_value <= m_max_value)
        else $error("mean outside min..max");

    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

endmodule

bind frame_min_max_mean fmm_checker u_fmm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_min_value  (m_min_value),
    .m_max_value  (m_max_value),
    .m_mean_value (m_mean_value)
);
